### rtl/four_axis_step_pulse_generator_assert.svh
// Assertion macros shared by the step pulse generator.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FOUR_AXIS_STEP_PULSE_GENERATOR_ASSERT_SVH
`define FOUR_AXIS_STEP_PULSE_GENERATOR_ASSERT_SVH

// Generic clocked check with a fixed message.
`define FASPG_CHECK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("step pulse generator check failed");

// Clocked check with a caller-supplied message.
`define FASPG_CHECK_MSG(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

### rtl/faspg_pkg.sv
package faspg_pkg;

	// Fixed field widths.
	localparam int AXES   = 4;
	localparam int AX_W   = $clog2(AXES);
	localparam int POS_W  = 31;
	localparam int ERR_W  = 32;
	localparam int RATE_W = 20;
	localparam int ALU_W  = 33;
	localparam int IN_W   = 128;
	localparam int OUT_W  = 136;

	localparam logic [RATE_W-1:0] RATE_RESET = 20'd1000;

	// Item function codes carried on tuser.
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_LOAD  = 2'd2
	} func_t;

	// Operation of the shared adder.
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef logic [AXES-1:0][POS_W-1:0] pos_vec_t;

	// One result item, packed with the step pins in the lowest bits.
	typedef struct packed {
		pos_vec_t  pos;
		logic      acc;
		logic      done;
		logic      busy;
		logic [3:0] dir;
		logic [3:0] step;
	} result_t;

endpackage

### rtl/four_axis_step_pulse_generator.sv
// Items are handled one at a time. A tick inside an iteration only advances the phase; a tick
// that opens the next iteration runs two adder steps per axis (three when it steps), and a move
// start runs the delta, abs and max steps per axis and then the QW-bit rate division,
// QW = clog2(TICK_HZ/2 + 1) = 19 at 1 MHz ticks.
// Reset (arst_n low, asynchronous): positions and errors zero, direction pins all ones,
// step rate 1000, no move in progress, output empty.
module four_axis_step_pulse_generator import faspg_pkg::*; #(
	parameter int TICK_HZ         = 1000000,
	parameter int MIN_HALF_PERIOD = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: step rate register.
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_wdata,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // target_j1, target_j2, target_z, target_j4, zero pad
	input  logic [1:0]        s_tuser,  // func
	// Output stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata   // step_pins, dir_pins, busy_res, move_done, accepted,
	                                    // pos_j1, pos_j2, pos_z, pos_j4, zero pad
);

	logic [RATE_W-1:0] rate_q;
	logic              out_valid_q;
	result_t           out_q;
	result_t           core_res;
	logic              core_res_valid;
	logic              out_free;

	// Step rate register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			rate_q <= cfg_wdata;
		end
	end

	faspg_core #(
		.TICK_HZ         (TICK_HZ),
		.MIN_HALF_PERIOD (MIN_HALF_PERIOD)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_tgt    (pos_vec_t'(s_tdata[AXES*POS_W-1:0])),
		.rate      (rate_q),
		.res_valid (core_res_valid),
		.res_take  (out_free),
		.res       (core_res)
	);

	// Output register; it frees the core while a result waits for its transfer.
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= core_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && core_res_valid) begin
			out_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_q};

	`include "four_axis_step_pulse_generator_assert.svh"

	// The core handles one item at a time.
	`FASPG_CHECK_MSG(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")
	// A refused item only happens during a move.
	`FASPG_CHECK(a_refuse_busy, (m_tvalid && !m_tdata[10]) |-> m_tdata[8])
	// Step pulses appear only while a move is in progress.
	`FASPG_CHECK(a_step_busy, (m_tvalid && (m_tdata[3:0] != 4'd0)) |-> m_tdata[8])
	// The item that ends a move reports the block idle.
	`FASPG_CHECK(a_done_idle, (m_tvalid && m_tdata[9]) |-> !m_tdata[8])

endmodule

### rtl/faspg_alu.sv
module faspg_alu import faspg_pkg::*; (
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	input  alu_op_t          op,
	output logic [ALU_W-1:0] sum
);

	logic [ALU_W-1:0] b_eff;

	// One adder serves both add and subtract; subtract inverts b and injects a carry.
	assign b_eff = (op == ALU_SUB) ? ~b : b;
	assign sum   = a + b_eff + {{(ALU_W-1){1'b0}}, (op == ALU_SUB)};

endmodule

### rtl/faspg_core.sv
module faspg_core import faspg_pkg::*; #(
	parameter int TICK_HZ         = 1000000,
	parameter int MIN_HALF_PERIOD = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_func,
	input  pos_vec_t          in_tgt,
	input  logic [RATE_W-1:0] rate,
	output logic              res_valid,
	input  logic              res_take,
	output result_t           res
);

	// Half period is floor(TICK_HZ/2 / rate), at least MIN_HALF_PERIOD, one quotient bit per cycle.
	localparam int HALF_TICKS = TICK_HZ / 2;
	localparam int QW         = $clog2(HALF_TICKS + 1);
	localparam int IW         = $clog2(QW);
	localparam int HP_MAX     = (HALF_TICKS > MIN_HALF_PERIOD) ? HALF_TICKS : MIN_HALF_PERIOD;
	localparam int HPW        = $clog2(HP_MAX + 1);
	localparam int PHW        = HPW + 1;
	localparam logic [QW-1:0] DIVIDEND = QW'(HALF_TICKS);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_DELTA = 12'b0000_0000_0010,
		S_ABS   = 12'b0000_0000_0100,
		S_MAX   = 12'b0000_0000_1000,
		S_CHK   = 12'b0000_0001_0000,
		S_DIV   = 12'b0000_0010_0000,
		S_HP    = 12'b0000_0100_0000,
		S_ACC   = 12'b0000_1000_0000,
		S_CMP   = 12'b0001_0000_0000,
		S_POS   = 12'b0010_0000_0000,
		S_TICK  = 12'b0100_0000_0000,
		S_RES   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	pos_vec_t                       pos_q;
	pos_vec_t                       tgt_q;
	logic [AXES-1:0][POS_W-1:0]     abs_q;
	logic [AXES-1:0][ERR_W-1:0]     err_q;
	logic [AXES-1:0]                dir_q;
	logic [AXES-1:0]                step_q;
	logic [POS_W-1:0]               big_q;
	logic [POS_W-1:0]               largest_q;
	logic [POS_W-1:0]               iter_q;
	logic [HPW-1:0]                 hp_q;
	logic [PHW-1:0]                 phase_q;
	logic                           moving_q;
	logic                           done_q;
	logic                           acc_q;
	logic [AX_W-1:0]                ax_q;
	logic [ALU_W-1:0]               d_q;
	logic [RATE_W-1:0]              rem_q;
	logic [QW-1:0]                  quo_q;
	logic [IW-1:0]                  div_idx_q;

	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic [ALU_W-1:0] alu_sum;
	alu_op_t          alu_op;
	logic             alu_neg;
	logic             ax_last;
	logic [PHW-1:0]   phase_nx;
	logic [POS_W-1:0] iter_nx;
	logic             iter_end;

	faspg_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.op  (alu_op),
		.sum (alu_sum)
	);

	assign alu_neg = alu_sum[ALU_W-1];
	assign ax_last = (ax_q == AX_W'(AXES - 1));

	// Operand selection for the shared adder in each step of the sequence.
	always_comb begin
		alu_a  = '0;
		alu_b  = '0;
		alu_op = ALU_ADD;
		unique case (state_q)
			S_DELTA: begin
				alu_a  = {{(ALU_W-POS_W){tgt_q[ax_q][POS_W-1]}}, tgt_q[ax_q]};
				alu_b  = {{(ALU_W-POS_W){pos_q[ax_q][POS_W-1]}}, pos_q[ax_q]};
				alu_op = ALU_SUB;
			end
			S_ABS: begin
				alu_b  = d_q;
				alu_op = d_q[ALU_W-1] ? ALU_SUB : ALU_ADD;
			end
			S_MAX: begin
				alu_a  = {{(ALU_W-POS_W){1'b0}}, big_q};
				alu_b  = {{(ALU_W-POS_W){1'b0}}, abs_q[ax_q]};
				alu_op = ALU_SUB;
			end
			S_DIV: begin
				alu_a  = {{(ALU_W-RATE_W-1){1'b0}}, rem_q, DIVIDEND[div_idx_q]};
				alu_b  = {{(ALU_W-RATE_W){1'b0}}, rate};
				alu_op = ALU_SUB;
			end
			S_ACC: begin
				alu_a  = {{(ALU_W-ERR_W){1'b0}}, err_q[ax_q]};
				alu_b  = {{(ALU_W-POS_W){1'b0}}, abs_q[ax_q]};
			end
			S_CMP: begin
				alu_a  = {{(ALU_W-ERR_W){1'b0}}, err_q[ax_q]};
				alu_b  = {{(ALU_W-POS_W){1'b0}}, largest_q};
				alu_op = ALU_SUB;
			end
			S_POS: begin
				alu_a  = {{(ALU_W-POS_W){1'b0}}, pos_q[ax_q]};
				alu_b  = ALU_W'(1);
				alu_op = dir_q[ax_q] ? ALU_ADD : ALU_SUB;
			end
			default: begin
			end
		endcase
	end

	// Tick bookkeeping on the narrow phase and iteration counters.
	assign phase_nx = phase_q + PHW'(1);
	assign iter_end = (phase_nx >= {hp_q, 1'b0});
	assign iter_nx  = iter_q - POS_W'(1);

	// Sequencer and move state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			abs_q     <= '0;
			err_q     <= '0;
			dir_q     <= '1;
			step_q    <= '0;
			big_q     <= '0;
			largest_q <= '0;
			iter_q    <= '0;
			phase_q   <= '0;
			moving_q  <= 1'b0;
			done_q    <= 1'b0;
			acc_q     <= 1'b1;
			ax_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						done_q <= 1'b0;
						tgt_q  <= in_tgt;
						// A start or a load is refused while a move runs.
						unique case (func_t'(in_func))
							FUNC_TICK: begin
								acc_q   <= 1'b1;
								state_q <= moving_q ? S_TICK : S_RES;
							end
							FUNC_START: begin
								acc_q <= !moving_q;
								if (moving_q) begin
									state_q <= S_RES;
								end else if (rate == '0) begin
									state_q <= S_RES;
								end else begin
									big_q   <= '0;
									ax_q    <= '0;
									state_q <= S_DELTA;
								end
							end
							FUNC_LOAD: begin
								acc_q <= !moving_q;
								if (!moving_q) begin
									pos_q <= in_tgt;
								end
								state_q <= S_RES;
							end
							default: begin
								acc_q   <= 1'b1;
								state_q <= S_RES;
							end
						endcase
					end
				end
				S_DELTA: begin
					d_q     <= alu_sum;
					state_q <= S_ABS;
				end
				S_ABS: begin
					abs_q[ax_q] <= alu_sum[POS_W-1:0];
					dir_q[ax_q] <= ~d_q[ALU_W-1];
					state_q     <= S_MAX;
				end
				S_MAX: begin
					if (alu_neg) begin
						big_q <= abs_q[ax_q];
					end
					if (ax_last) begin
						ax_q    <= '0;
						state_q <= S_CHK;
					end else begin
						ax_q    <= ax_q + AX_W'(1);
						state_q <= S_DELTA;
					end
				end
				S_CHK: begin
					if (big_q == '0) begin
						state_q <= S_RES;
					end else begin
						largest_q <= big_q;
						iter_q    <= big_q;
						err_q     <= '0;
						rem_q     <= '0;
						div_idx_q <= IW'(QW - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					// On a failed trial the shifted partial remainder is kept.
					if (!alu_neg) begin
						rem_q <= alu_sum[RATE_W-1:0];
					end else begin
						rem_q <= {rem_q[RATE_W-2:0], DIVIDEND[div_idx_q]};
					end
					quo_q <= {quo_q[QW-2:0], ~alu_neg};
					if (div_idx_q == '0) begin
						state_q <= S_HP;
					end else begin
						div_idx_q <= div_idx_q - IW'(1);
					end
				end
				S_HP: begin
					if (HPW'(quo_q) < HPW'(MIN_HALF_PERIOD)) begin
						hp_q <= HPW'(MIN_HALF_PERIOD);
					end else begin
						hp_q <= HPW'(quo_q);
					end
					moving_q <= 1'b1;
					step_q   <= '0;
					phase_q  <= '0;
					ax_q     <= '0;
					state_q  <= S_ACC;
				end
				S_ACC: begin
					err_q[ax_q] <= alu_sum[ERR_W-1:0];
					state_q     <= S_CMP;
				end
				S_CMP: begin
					if (!alu_neg) begin
						err_q[ax_q]  <= alu_sum[ERR_W-1:0];
						step_q[ax_q] <= 1'b1;
						state_q      <= S_POS;
					end else if (ax_last) begin
						ax_q    <= '0;
						state_q <= S_RES;
					end else begin
						ax_q    <= ax_q + AX_W'(1);
						state_q <= S_ACC;
					end
				end
				S_POS: begin
					pos_q[ax_q] <= alu_sum[POS_W-1:0];
					if (ax_last) begin
						ax_q    <= '0;
						state_q <= S_RES;
					end else begin
						ax_q    <= ax_q + AX_W'(1);
						state_q <= S_ACC;
					end
				end
				S_TICK: begin
					if (iter_end) begin
						iter_q  <= iter_nx;
						step_q  <= '0;
						phase_q <= '0;
						if (iter_nx == '0) begin
							moving_q <= 1'b0;
							done_q   <= 1'b1;
							state_q  <= S_RES;
						end else begin
							ax_q    <= '0;
							state_q <= S_ACC;
						end
					end else begin
						phase_q <= phase_nx;
						if (phase_nx == {1'b0, hp_q}) begin
							step_q <= '0;
						end
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RES);

	// Result fields come straight from the move state.
	always_comb begin
		res.pos  = pos_q;
		res.acc  = acc_q;
		res.done = done_q;
		res.busy = moving_q;
		res.dir  = dir_q;
		res.step = step_q;
	end

endmodule

### test/four_axis_step_pulse_generator_tb.sv
module four_axis_step_pulse_generator_tb;
	import faspg_pkg::*;

	localparam int TICK_HZ = 1000000;
	localparam int MIN_HALF = 2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_PCT = 17;
	localparam int RANDOM_ITEMS = 600;
	localparam int HOLD_AT = 200;
	localparam int HOLD_LEN = 400;
	localparam int SETTLE = 20;
	localparam int DRAIN = 60;
	localparam int CYCLE_LIMIT = 500000;
	localparam int REPORT_MAX = 10;
	localparam int POS_MAX = 1073741823;
	localparam int POS_MIN = -1073741824;

	// One command on the input stream: function code and four axis values.
	typedef struct packed {
		logic [1:0] code;
		logic [AXES-1:0][POS_W-1:0] tgt;
	} motion_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RATE_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	four_axis_step_pulse_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Commands waiting to be sent and pin states waiting to come back.
	motion_cmd_t motion_cmds[$];
	result_t pin_states_due[$];

	logic offering = 1'b0;
	logic calm = 1'b0;
	logic held = 1'b0;
	int hold_left = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycles = 0;
	int planned = 0;

	// Predicted state of the generator.
	logic [POS_W-1:0] pos_now[AXES] = '{default: '0};
	logic [POS_W-1:0] cnt[AXES] = '{default: '0};
	logic [ERR_W-1:0] err[AXES] = '{default: '0};
	logic [3:0] dir_now = 4'hF;
	logic [3:0] step_now = 4'h0;
	logic [POS_W-1:0] longest = '0;
	logic [POS_W-1:0] left = '0;
	logic [18:0] half = 19'd2;
	logic [19:0] phase = '0;
	logic busy_now = 1'b0;
	logic [RATE_W-1:0] rate_now = RATE_RESET;

	// Stimulus shadow: positions and rate as the command stream leaves them.
	int plan_pos[AXES] = '{default: 0};
	logic [RATE_W-1:0] plan_rate = RATE_RESET;

	// Ticks per half step period for a nonzero rate.
	function automatic logic [18:0] half_for(logic [RATE_W-1:0] rate);
		int h;
		h = TICK_HZ / (2 * int'(rate));
		if (h < MIN_HALF)
			h = MIN_HALF;
		return h[18:0];
	endfunction

	// Bresenham update at the start of each step iteration.
	function automatic void open_iteration();
		step_now = '0;
		for (int a = 0; a < AXES; a++) begin
			err[a] = err[a] + {1'b0, cnt[a]};
			if (err[a] >= {1'b0, longest}) begin
				err[a] = err[a] - {1'b0, longest};
				step_now[a] = 1'b1;
				pos_now[a] = dir_now[a] ? pos_now[a] + 31'd1 : pos_now[a] - 31'd1;
			end
		end
		phase = '0;
	endfunction

	// Advances the predicted state by one command and returns the pin state it shows.
	function automatic result_t next_pin_state(motion_cmd_t c);
		result_t r;
		logic took;
		logic fin;
		longint d;
		longint mag;
		logic [POS_W-1:0] big;
		took = 1'b1;
		fin = 1'b0;
		case (c.code)
		FUNC_TICK: begin
			if (busy_now) begin
				phase = phase + 20'd1;
				if (phase == 20'(half))
					step_now = '0;
				if (phase >= {half, 1'b0}) begin
					left = left - 31'd1;
					if (left == '0) begin
						busy_now = 1'b0;
						fin = 1'b1;
						phase = '0;
						step_now = '0;
					end else begin
						open_iteration();
					end
				end
			end
		end
		FUNC_START: begin
			if (busy_now) begin
				took = 1'b0;
			end else if (rate_now != '0) begin
				big = '0;
				dir_now = '0;
				for (int a = 0; a < AXES; a++) begin
					d = longint'($signed(c.tgt[a])) - longint'($signed(pos_now[a]));
					dir_now[a] = (d >= 0);
					mag = (d >= 0) ? d : -d;
					cnt[a] = mag[POS_W-1:0];
					if (cnt[a] > big)
						big = cnt[a];
				end
				if (big != '0) begin
					longest = big;
					left = big;
					half = half_for(rate_now);
					for (int a = 0; a < AXES; a++)
						err[a] = '0;
					busy_now = 1'b1;
					open_iteration();
				end
			end
		end
		FUNC_LOAD: begin
			if (busy_now)
				took = 1'b0;
			else
				for (int a = 0; a < AXES; a++)
					pos_now[a] = c.tgt[a];
		end
		default: ;
		endcase
		r.step = step_now;
		r.dir = dir_now;
		r.busy = busy_now;
		r.done = fin;
		r.acc = took;
		for (int a = 0; a < AXES; a++)
			r.pos[a] = pos_now[a];
		return r;
	endfunction

	// Clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Run timeout.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("four_axis_step_pulse_generator regression: fail");
			$finish;
		end
	end

	// Sender: presents the oldest pending command, with random gaps.
	always @(negedge clk) begin
		if (arst_n && !offering && motion_cmds.size() != 0 &&
				(calm || $urandom_range(99) >= IDLE_PCT)) begin
			s_tvalid <= 1'b1;
			s_tdata <= {{(IN_W - AXES * POS_W){1'b0}}, motion_cmds[0].tgt};
			s_tuser <= motion_cmds[0].code;
			offering = 1'b1;
		end else if (!offering) begin
			s_tvalid <= 1'b0;
		end
	end

	// Input transfer: predict the pin state this command produces.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pin_states_due.push_back(next_pin_state(motion_cmds.pop_front()));
			offering = 1'b0;
		end
	end

	// Receiver: random stalls plus one long hold-off once traffic is flowing.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (!held && results_seen >= HOLD_AT) begin
			held = 1'b1;
			hold_left = HOLD_LEN;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Output transfer: compare against the oldest predicted pin state.
	always @(posedge clk) begin : check_blk
		result_t got;
		result_t want;
		if (m_tvalid && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			results_seen++;
			if (pin_states_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: step=%h dir=%h busy=%b done=%b acc=%b",
						got.step, got.dir, got.busy, got.done, got.acc);
			end else begin
				want = pin_states_due.pop_front();
				if (want.step !== got.step || want.dir !== got.dir ||
						want.busy !== got.busy || want.done !== got.done ||
						want.acc !== got.acc || want.pos[0] !== got.pos[0] ||
						want.pos[1] !== got.pos[1] || want.pos[2] !== got.pos[2] ||
						want.pos[3] !== got.pos[3]) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("result %0d expected: step=%h dir=%h busy=%b done=%b acc=%b pos=%h %h %h %h",
							results_seen, want.step, want.dir, want.busy, want.done, want.acc,
							want.pos[0], want.pos[1], want.pos[2], want.pos[3]);
						$display("result %0d actual:   step=%h dir=%h busy=%b done=%b acc=%b pos=%h %h %h %h",
							results_seen, got.step, got.dir, got.busy, got.done, got.acc,
							got.pos[0], got.pos[1], got.pos[2], got.pos[3]);
					end
				end
			end
		end
	end

	function automatic logic [AXES-1:0][POS_W-1:0] random_tgt();
		logic [AXES-1:0][POS_W-1:0] t;
		for (int a = 0; a < AXES; a++)
			t[a] = $urandom();
		return t;
	endfunction

	task automatic add_item(logic [1:0] code, logic [AXES-1:0][POS_W-1:0] tgt);
		motion_cmd_t c;
		c.code = code;
		c.tgt = tgt;
		motion_cmds.push_back(c);
		planned++;
	endtask

	// A command that a running move must refuse or ignore.
	task automatic add_noise();
		int pick;
		pick = $urandom_range(2);
		if (pick == 0)
			add_item(FUNC_START, random_tgt());
		else if (pick == 1)
			add_item(FUNC_LOAD, random_tgt());
		else
			add_item(FUNC_UNUSED, random_tgt());
	endtask

	// Loads the given positions into all four axes.
	task automatic load_positions(int p0, int p1, int p2, int p3);
		logic [AXES-1:0][POS_W-1:0] tg;
		tg = {31'(p3), 31'(p2), 31'(p1), 31'(p0)};
		add_item(FUNC_LOAD, tg);
		for (int a = 0; a < AXES; a++)
			plan_pos[a] = int'($signed(tg[a]));
	endtask

	task automatic load_random();
		int v[AXES];
		for (int a = 0; a < AXES; a++) begin
			case ($urandom_range(5))
			0: v[a] = POS_MIN;
			1: v[a] = POS_MAX;
			default: v[a] = int'($signed(31'($urandom())));
			endcase
		end
		load_positions(v[0], v[1], v[2], v[3]);
	endtask

	// Starts a move by the given offsets and sends exactly the ticks that finish it.
	task automatic run_move(int d0, int d1, int d2, int d3, int noise_pct);
		int dl[AXES];
		longint t;
		longint span;
		int big;
		int ticks;
		logic [AXES-1:0][POS_W-1:0] tg;
		dl = '{d0, d1, d2, d3};
		big = 0;
		for (int a = 0; a < AXES; a++) begin
			t = longint'(plan_pos[a]) + dl[a];
			if (t > POS_MAX || t < POS_MIN)
				t = longint'(plan_pos[a]) - dl[a];
			tg[a] = t[POS_W-1:0];
			span = (t > plan_pos[a]) ? t - plan_pos[a] : plan_pos[a] - t;
			if (span > big)
				big = int'(span);
		end
		add_item(FUNC_START, tg);
		if (plan_rate == '0 || big == 0)
			return;
		ticks = 2 * int'(half_for(plan_rate)) * big;
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(99) < noise_pct)
				add_noise();
			add_item(FUNC_TICK, random_tgt());
		end
		for (int a = 0; a < AXES; a++)
			plan_pos[a] = int'($signed(tg[a]));
	endtask

	function automatic int rand_offset();
		int m;
		m = $urandom_range(4);
		return $urandom_range(1) ? -m : m;
	endfunction

	task automatic random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20)
			load_random();
		if (pick >= 90) begin
			add_item(FUNC_UNUSED, random_tgt());
			add_item(FUNC_TICK, random_tgt());
		end
		if (plan_rate == '0)
			add_item(FUNC_START, random_tgt());
		else if (pick >= 20 && pick < 28)
			run_move(0, 0, 0, 0, 0);
		else
			run_move(rand_offset(), rand_offset(), rand_offset(), rand_offset(), 6);
	endtask

	// Writes the step rate once the block has returned every result.
	task automatic write_rate(logic [RATE_W-1:0] v);
		while (motion_cmds.size() != 0 || pin_states_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		rate_now = v;
		plan_rate = v;
	endtask

	// Main sequence.
	initial begin : main_blk
		int phase_no;
		int stop_at;
		logic [RATE_W-1:0] r;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Idle behavior at the reset rate: unused code, idle tick, load, null move.
		add_item(FUNC_UNUSED, random_tgt());
		add_item(FUNC_TICK, random_tgt());
		load_positions(POS_MIN, POS_MAX, 0, -1);
		run_move(0, 0, 0, 0, 0);

		// Zero rate: starts do nothing.
		write_rate('0);
		add_item(FUNC_START, random_tgt());
		run_move(3, -2, 0, 1, 0);
		load_positions(POS_MIN, POS_MAX, 0, -1);

		// Fastest rate with refused and ignored commands mid-move.
		write_rate(20'd1000000);
		run_move(-3, 2, 0, 1, 100);
		run_move(-1, -1, -1, -4, 0);
		run_move(2, 2, 2, 2, 0);

		// Random phases across the usable rate range.
		stop_at = planned + RANDOM_ITEMS;
		phase_no = 0;
		while (planned < stop_at) begin
			case ($urandom_range(9))
			0: r = 20'd1000000;
			1: r = 20'hFFFFF;
			2: r = 20'd500000;
			3: r = 20'd250000;
			4: r = 20'd166667;
			5: r = 20'd166666;
			6: r = 20'd125000;
			7: r = 20'd100000;
			8: r = (phase_no % 3 == 0) ? 20'd0 : 20'($urandom_range(1000000, 100000));
			default: r = 20'($urandom_range(1000000, 100000));
			endcase
			write_rate(r);
			calm = (phase_no == 2);
			repeat (6) random_sequence();
			phase_no++;
		end

		// Slowest rate: only loads and null moves are affordable.
		write_rate(20'd1);
		calm = 1'b0;
		load_random();
		run_move(0, 0, 0, 0, 0);

		// A slow single-step move.
		write_rate(20'd5000);
		run_move(0, 0, -1, 0, 2);

		while (motion_cmds.size() != 0 || pin_states_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && pin_states_due.size() == 0)
			$display("four_axis_step_pulse_generator regression: pass");
		else
			$display("four_axis_step_pulse_generator regression: fail");
		$finish;
	end

endmodule
